[design/bmpt_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bmpt_pkg
// Shared types and codes for the bounded max-priority table.
// ----------------------------------------------------------------------------
package bmpt_pkg;

    localparam int HANDLE_W = 32;
    localparam int PRIO_W   = 32;
    localparam int STATUS_W = 3;

    // request kinds, carried on s_tuser
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_DELETE = 1'b1;

    // result status codes, carried on m_tuser
    localparam logic [STATUS_W-1:0] STAT_INSERTED = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_NULL     = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_DELETED  = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_EMPTY    = 3'd4;

    // one word of the slot memory
    typedef struct packed {
        logic                     valid;
        logic [HANDLE_W-1:0]      handle;
        logic signed [PRIO_W-1:0] prio;
    } bmpt_entry_t;

    // control from the sequencer to the scan tracker
    typedef struct packed {
        logic start;
        logic rd_vld;
        logic is_delete;
    } bmpt_scan_ctl_t;

endpackage : bmpt_pkg
`default_nettype wire

[design/bmpt_scan.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bmpt_scan
// Tracks the scan over the slot memory: the first free slot for an insert,
// or the highest-priority valid slot for a delete-max (ties go to the later
// slot, since slots arrive in ascending order).
// ----------------------------------------------------------------------------
module bmpt_scan
    import bmpt_pkg::*;
#(
    parameter int IDX_W = 4
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire bmpt_scan_ctl_t      ctl,
    input  wire logic [IDX_W-1:0]    rd_idx,
    input  wire bmpt_entry_t         rd_entry,
    output logic                     found,
    output logic [IDX_W-1:0]         best_idx,
    output logic [HANDLE_W-1:0]      best_handle
);

    logic                     found_reg, found_next;
    logic [IDX_W-1:0]         best_idx_reg, best_idx_next;
    logic signed [PRIO_W-1:0] best_prio_reg, best_prio_next;
    logic [HANDLE_W-1:0]      best_handle_reg, best_handle_next;
    logic                     take;

    always_comb begin
        if (ctl.is_delete) begin
            take = ctl.rd_vld && rd_entry.valid &&
                   (!found_reg || ($signed(rd_entry.prio) >= best_prio_reg));
        end else begin
            take = ctl.rd_vld && !rd_entry.valid && !found_reg;
        end

        found_next       = found_reg;
        best_idx_next    = best_idx_reg;
        best_prio_next   = best_prio_reg;
        best_handle_next = best_handle_reg;
        if (ctl.start) begin
            found_next = 1'b0;
        end else if (take) begin
            found_next       = 1'b1;
            best_idx_next    = rd_idx;
            best_prio_next   = rd_entry.prio;
            best_handle_next = rd_entry.handle;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else begin
            found_reg <= found_next;
        end
        best_idx_reg    <= best_idx_next;
        best_prio_reg   <= best_prio_next;
        best_handle_reg <= best_handle_next;
    end

    assign found       = found_reg;
    assign best_idx    = best_idx_reg;
    assign best_handle = best_handle_reg;

endmodule : bmpt_scan
`default_nettype wire

[design/bounded_max_priority_table_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_max_priority_table_core
// Table of CAPACITY (handle, signed priority) slots in a single-port-read,
// single-port-write memory: insert into the lowest free slot, delete-max
// returns and frees the highest-priority slot (ties to the highest index).
// ----------------------------------------------------------------------------
// sequencing: a null insert skips the scan and goes from IDLE straight to
//   DONE; any other request runs SCAN, one memory read per slot visited,
//   then WRITE if a slot was picked, then DONE
// throughput: one item at a time, set by the one-slot-per-cycle memory scan
//   (an insert stops at the first free slot); s_tready returns as the result register loads, which can wait on m_tready
// reset: a clearing pass marks every slot free; s_tready stays low until it
//   ends
module bounded_max_priority_table_core
    import bmpt_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [63:0]           s_tdata,  // [31:0] data_handle, [63:32] priority_req
    input  wire logic [0:0]            s_tuser,  // [0] req_type
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [31:0]                m_tdata,  // [31:0] data_out
    output logic [2:0]                 m_tuser   // [2:0] status
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_SCAN  = 5'b00100,
        S_WRITE = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t                   state_reg, state_next;
    logic [IDX_W-1:0]         clr_cnt_reg, clr_cnt_next;
    logic [CNT_W-1:0]         issue_cnt_reg, issue_cnt_next;
    logic                     rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0]         rd_idx_reg, rd_idx_next;
    logic                     req_reg, req_next;
    logic [HANDLE_W-1:0]      handle_reg, handle_next;
    logic signed [PRIO_W-1:0] prio_reg, prio_next;
    logic [STATUS_W-1:0]      res_stat_reg, res_stat_next;
    logic [HANDLE_W-1:0]      res_data_reg, res_data_next;
    logic                     m_tvalid_reg, m_tvalid_next;
    logic [STATUS_W-1:0]      m_stat_reg, m_stat_next;
    logic [HANDLE_W-1:0]      m_data_reg, m_data_next;

    // slot memory
    bmpt_entry_t              mem [CAPACITY];
    bmpt_entry_t              mem_rdata_reg;
    logic                     mem_we;
    logic [IDX_W-1:0]         mem_waddr;
    bmpt_entry_t              mem_wdata;
    logic [IDX_W-1:0]         mem_raddr;

    bmpt_scan_ctl_t           scan_ctl;
    logic                     scan_found;
    logic [IDX_W-1:0]         scan_best_idx;
    logic [HANDLE_W-1:0]      scan_best_handle;

    logic                     in_fire;
    logic                     issuing;
    logic                     scan_done;

    assign s_tready = (state_reg == S_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign issuing  = (state_reg == S_SCAN) && (issue_cnt_reg < CNT_W'(CAPACITY));
    assign mem_raddr = issuing ? issue_cnt_reg[IDX_W-1:0] : '0;
    assign scan_done = (scan_found && (req_reg == REQ_INSERT)) ||
                       ((issue_cnt_reg == CNT_W'(CAPACITY)) && !rd_vld_reg);

    assign scan_ctl.start     = in_fire;
    assign scan_ctl.rd_vld    = rd_vld_reg && (state_reg == S_SCAN);
    assign scan_ctl.is_delete = (req_reg == REQ_DELETE);

    bmpt_scan #(
        .IDX_W (IDX_W)
    ) u_scan (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctl         (scan_ctl),
        .rd_idx      (rd_idx_reg),
        .rd_entry    (mem_rdata_reg),
        .found       (scan_found),
        .best_idx    (scan_best_idx),
        .best_handle (scan_best_handle)
    );

    always_comb begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        issue_cnt_next = issue_cnt_reg;
        rd_vld_next    = 1'b0;
        rd_idx_next    = rd_idx_reg;
        req_next       = req_reg;
        handle_next    = handle_reg;
        prio_next      = prio_reg;
        res_stat_next  = res_stat_reg;
        res_data_next  = res_data_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_stat_next    = m_stat_reg;
        m_data_next    = m_data_reg;
        mem_we         = 1'b0;
        mem_waddr      = scan_best_idx;
        mem_wdata      = '0;

        unique case (state_reg)
            S_CLEAR: begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == IDX_W'(CAPACITY - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_fire) begin
                    req_next       = s_tuser[0];
                    handle_next    = s_tdata[31:0];
                    prio_next      = s_tdata[63:32];
                    issue_cnt_next = '0;
                    if ((s_tuser[0] == REQ_INSERT) && (s_tdata[31:0] == '0)) begin
                        res_stat_next = STAT_NULL;
                        res_data_next = '0;
                        state_next    = S_DONE;
                    end else begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (issuing) begin
                    rd_vld_next    = 1'b1;
                    rd_idx_next    = issue_cnt_reg[IDX_W-1:0];
                    issue_cnt_next = issue_cnt_reg + 1'b1;
                end
                if (scan_done) begin
                    rd_vld_next = 1'b0;
                    if (scan_found) begin
                        state_next = S_WRITE;
                    end else begin
                        res_stat_next = (req_reg == REQ_DELETE) ? STAT_EMPTY : STAT_FULL;
                        res_data_next = '0;
                        state_next    = S_DONE;
                    end
                end
            end
            S_WRITE: begin
                mem_we = 1'b1;
                if (req_reg == REQ_DELETE) begin
                    res_stat_next = STAT_DELETED;
                    res_data_next = scan_best_handle;
                end else begin
                    mem_wdata.valid  = 1'b1;
                    mem_wdata.handle = handle_reg;
                    mem_wdata.prio   = prio_reg;
                    res_stat_next    = STAT_INSERTED;
                    res_data_next    = '0;
                end
                state_next = S_DONE;
            end
            S_DONE: begin
                // wait for the output register to free up
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_stat_next   = res_stat_reg;
                    m_data_next   = res_data_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            issue_cnt_reg <= '0;
            rd_vld_reg    <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            issue_cnt_reg <= issue_cnt_next;
            rd_vld_reg    <= rd_vld_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
        rd_idx_reg   <= rd_idx_next;
        req_reg      <= req_next;
        handle_reg   <= handle_next;
        prio_reg     <= prio_next;
        res_stat_reg <= res_stat_next;
        res_data_reg <= res_data_next;
        m_stat_reg   <= m_stat_next;
        m_data_reg   <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= mem[mem_raddr];
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_stat_reg;
    assign m_tdata  = m_data_reg;

    // a write-back only happens once the scan has picked a slot
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WRITE) |-> scan_found)
        else $error("slot write-back without a selected slot");

    // a removed handle is never the null handle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == STAT_DELETED)) |-> (m_tdata != '0))
        else $error("delete-max returned a null handle");

    // every result other than a delete carries a zero handle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser != STAT_DELETED)) |-> (m_tdata == '0))
        else $error("non-delete result carries a handle");

endmodule : bounded_max_priority_table_core
`default_nettype wire
